// File: rtl/binary_to_decimal_ascii_macros.svh
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/b2da_pkg.sv
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W         = 32;
    localparam int BYTE_W          = 8;
    localparam int CHAR_W          = 6;
    localparam int COUNT_W         = 4;
    localparam int DIGIT_W         = 4;
    localparam int DEF_MAX_BYTES   = 4;
    localparam int DEF_DIGIT_SLOTS = 10;

    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef enum logic [1:0] {
        ST_GATHER,
        ST_DIV,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic gather;
        logic start;
        logic div;
        logic digit;
        logic clear;
        logic emit_init;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic value_zero;
        logic slots_full;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/b2da_ctrl.sv
`default_nettype none

module b2da_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              is_last_byte,
    input  wire b2da_pkg::status_t status,
    output b2da_pkg::cmd_t         cmd
);
    import b2da_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_GATHER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_GATHER:
            begin
                if (in_valid && is_last_byte)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.value_zero || status.slots_full)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                state_next = ST_DIV;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = ST_GATHER;
                end
            end
            default:
            begin
                state_next = ST_GATHER;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_GATHER:
            begin
                in_ready   = 1'b1;
                cmd.gather = in_valid;
                cmd.start  = in_valid && is_last_byte;
            end
            ST_DIV:
            begin
                if (status.value_zero || status.slots_full)
                begin
                    cmd.clear     = 1'b1;
                    cmd.emit_init = 1'b1;
                end
                else
                begin
                    cmd.div = 1'b1;
                end
            end
            ST_DIGIT:
            begin
                cmd.digit = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/b2da_dpath.sv
`default_nettype none

module b2da_dpath #(
    parameter int MAX_BYTES   = b2da_pkg::DEF_MAX_BYTES,
    parameter int DIGIT_SLOTS = b2da_pkg::DEF_DIGIT_SLOTS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [b2da_pkg::BYTE_W-1:0]    data_byte,
    input  wire b2da_pkg::cmd_t                 cmd,
    output b2da_pkg::status_t                   status,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [b2da_pkg::CHAR_W-1:0]         digit_char,
    output logic                                has_digit,
    output logic [b2da_pkg::COUNT_W-1:0]        digit_count,
    output logic                                is_last_digit
);
    import b2da_pkg::*;

    localparam int POS_W = $clog2(MAX_BYTES + 1);
    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
    localparam int IDX_W = $clog2(DIGIT_SLOTS);

    logic [VALUE_W-1:0]   value_reg;
    logic [VALUE_W-1:0]   value_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [VALUE_W-1:0]   quot_reg;
    logic [2*VALUE_W-1:0] product;
    logic [VALUE_W-1:0]   quot_times_ten;
    logic [VALUE_W-1:0]   remainder;
    logic [DIGIT_W-1:0]   store_reg [DIGIT_SLOTS];
    logic [CNT_W-1:0]     found_reg;
    logic [CNT_W-1:0]     found_next;
    logic [CNT_W-1:0]     emit_reg;
    logic [CNT_W-1:0]     emit_next;
    logic [CNT_W-1:0]     emit_minus_one;
    logic [DIGIT_W-1:0]   read_digit;
    logic                 out_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 has_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 last_reg;

    assign product        = {{VALUE_W{1'b0}}, value_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot_times_ten = {quot_reg[VALUE_W-4:0], 3'b000} + {quot_reg[VALUE_W-2:0], 1'b0};
    assign remainder      = value_reg - quot_times_ten;
    assign emit_minus_one = emit_reg - CNT_W'(1);
    assign read_digit     = store_reg[emit_minus_one[IDX_W-1:0]];

    always_comb
    begin
        value_next = value_reg;
        pos_next   = pos_reg;
        if (cmd.clear)
        begin
            value_next = '0;
            pos_next   = '0;
        end
        else if (cmd.digit)
        begin
            value_next = quot_reg;
        end
        else if (cmd.gather && (pos_reg < POS_W'(MAX_BYTES)))
        begin
            for (int b = 0; b < MAX_BYTES; b++)
            begin
                if (pos_reg == POS_W'(b))
                begin
                    value_next[b*BYTE_W +: BYTE_W] = value_reg[b*BYTE_W +: BYTE_W] | data_byte;
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        found_next = found_reg;
        if (cmd.start)
        begin
            found_next = '0;
        end
        else if (cmd.digit)
        begin
            found_next = found_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        emit_next = emit_reg;
        if (cmd.emit_init)
        begin
            emit_next = found_reg;
        end
        else if (cmd.emit_load && (emit_reg != '0))
        begin
            emit_next = emit_minus_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg     <= '0;
            pos_reg       <= '0;
            found_reg     <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            pos_reg   <= pos_next;
            found_reg <= found_next;
            emit_reg  <= emit_next;
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div)
        begin
            quot_reg <= VALUE_W'(product >> RECIP_SHIFT);
        end
        if (cmd.digit)
        begin
            store_reg[found_reg[IDX_W-1:0]] <= remainder[DIGIT_W-1:0];
        end
        if (cmd.emit_load)
        begin
            has_reg   <= (emit_reg != '0);
            count_reg <= COUNT_W'(found_reg);
            last_reg  <= status.emit_last;
            if (emit_reg != '0)
            begin
                char_reg <= ASCII_ZERO + CHAR_W'(read_digit);
            end
            else
            begin
                char_reg <= '0;
            end
        end
    end

    assign status.value_zero = (value_reg == '0);
    assign status.slots_full = (found_reg == CNT_W'(DIGIT_SLOTS));
    assign status.emit_last  = (emit_reg <= CNT_W'(1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign digit_char    = char_reg;
    assign has_digit     = has_reg;
    assign digit_count   = count_reg;
    assign is_last_digit = last_reg;

endmodule

`default_nettype wire

// File: rtl/binary_to_decimal_ascii.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_ready  | data_byte[7:0], is_last_byte
// output   | out_valid / out_ready| digit_char[5:0], has_digit, digit_count[3:0],
//          |                      | is_last_digit
//
// A byte that is not the last is taken while the block is in its gather state.
// After the last byte, the divide-by-ten unit works each digit in a divide step
// (reciprocal multiply), then a digit step (remainder), and stops on a divide step
// that finds the value zero or every digit slot full. Digits then leave at one per
// cycle through the output register while out_ready stays high.
// Reset is asynchronous, active low, and clears the gather and control state.
// A stalled output holds its item; input stays blocked until the last digit is loaded.

`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

module binary_to_decimal_ascii #(
    parameter int MAX_BYTES   = b2da_pkg::DEF_MAX_BYTES,
    parameter int DIGIT_SLOTS = b2da_pkg::DEF_DIGIT_SLOTS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [b2da_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        is_last_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
    output logic                             has_digit,
    output logic [b2da_pkg::COUNT_W-1:0]     digit_count,
    output logic                             is_last_digit
);
    import b2da_pkg::*;

    cmd_t    cmd;
    status_t status;

    b2da_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .is_last_byte (is_last_byte),
        .status       (status),
        .cmd          (cmd)
    );

    b2da_dpath #(
        .MAX_BYTES   (MAX_BYTES),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .digit_char    (digit_char),
        .has_digit     (has_digit),
        .digit_count   (digit_count),
        .is_last_digit (is_last_digit)
    );

    `B2DA_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && is_last_byte,
        !in_ready, "input not blocked after last byte")
    `B2DA_ASSERT_NOW(a_digit_range, out_valid && has_digit,
        (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE) && (digit_count != '0),
        "digit item out of range")
    `B2DA_ASSERT_NOW(a_zero_item, out_valid && !has_digit,
        is_last_digit && (digit_count == '0) && (digit_char == '0),
        "zero-value item malformed")
    `B2DA_ASSERT_NEXT(a_emit_when_free, cmd.emit_load, out_valid,
        "emitted item not presented")

endmodule

`default_nettype wire
